// File: design/lssk_pkg.sv
// Shared types, constants and handshake structs for the longest subarray sum block.
package lssk_pkg;

	// Hash table geometry.
	localparam int unsigned TABLE_DEPTH = 1024;
	localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
	localparam bit          DEPTH_POW2  = ((TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0);

	// Field widths.
	localparam int unsigned KEY_W   = 64;
	localparam int unsigned ELEM_W  = 32;
	localparam int unsigned POS_W   = 16;
	localparam int unsigned EPOCH_W = 8;

	// Item limit: the smaller of the configured maximum and what a position can hold.
	localparam longint unsigned MAX_ITEMS = 64'd65535;
	localparam logic [POS_W-1:0] ITEM_LIMIT =
		POS_W'((MAX_ITEMS < 64'd65535) ? MAX_ITEMS : 64'd65535);

	// Home slot reduction: bits folded per cycle, and cycles per key.
	localparam int unsigned HASH_BITS  = 4;
	localparam int unsigned HASH_STEPS = DEPTH_POW2 ? 1 : KEY_W / HASH_BITS;
	localparam int unsigned HCNT_W     = $clog2(KEY_W / HASH_BITS + 1);

	typedef logic [KEY_W-1:0]   key_t;
	typedef logic [IDX_W-1:0]   idx_t;
	typedef logic [IDX_W:0]     trial_t;
	typedef logic [POS_W-1:0]   pos_t;
	typedef logic [EPOCH_W-1:0] epoch_t;
	typedef logic [HCNT_W-1:0]  hcnt_t;

	localparam epoch_t EPOCH_FIRST = epoch_t'(1);
	localparam epoch_t EPOCH_LAST  = '1;

	// One table entry; an entry belongs to the current array only if its epoch matches.
	typedef struct packed {
		epoch_t epoch;
		key_t   sum;
		pos_t   pos;
	} entry_t;

	// Controller states.
	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_KEY,
		S_HSTART,
		S_HWAIT,
		S_CHECK,
		S_RESULT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_item;
		logic load_key;
		logic phase_b;
		logic hash_start;
		logic probe_first;
		logic probe_next;
		logic hit_update;
		logic insert;
		logic set_ovf;
		logic finish;
		logic clr_write;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic limit_hit;
		logic hash_done;
		logic entry_valid;
		logic key_match;
		logic probe_last;
		logic last_item;
		logic clr_last;
		logic epoch_wrap;
	} status_t;

endpackage

// File: design/lssk_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module lssk_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: design/lssk_hash.sv
// Home slot unit: absolute value of a 64-bit key reduced modulo the table depth.
module lssk_hash (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  lssk_pkg::key_t      key,
	output logic                done,
	output lssk_pkg::idx_t      slot
);

	logic                busy_q;
	lssk_pkg::hcnt_t     cnt_q;
	lssk_pkg::key_t      mag_q;
	lssk_pkg::idx_t      rem_q;
	lssk_pkg::key_t      mag_abs;
	lssk_pkg::idx_t      rem_step;
	lssk_pkg::trial_t    trial;
	lssk_pkg::idx_t      rem_next;

	// Magnitude of the key; the most negative value maps to 2^63 as unsigned.
	assign mag_abs = key[lssk_pkg::KEY_W-1] ? (~key + lssk_pkg::key_t'(1)) : key;

	// Fold a few magnitude bits into the remainder, most significant first.
	always_comb begin
		rem_step = rem_q;
		trial    = '0;
		for (int i = 0; i < lssk_pkg::HASH_BITS; i++) begin
			trial = {rem_step, mag_q[lssk_pkg::KEY_W-1-i]};
			if (trial >= lssk_pkg::trial_t'(lssk_pkg::TABLE_DEPTH)) begin
				trial = trial - lssk_pkg::trial_t'(lssk_pkg::TABLE_DEPTH);
			end
			rem_step = trial[lssk_pkg::IDX_W-1:0];
		end
		rem_next = lssk_pkg::DEPTH_POW2 ? mag_q[lssk_pkg::IDX_W-1:0] : rem_step;
	end

	assign done = busy_q && (cnt_q == lssk_pkg::hcnt_t'(1));
	assign slot = rem_next;

	// Step control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= lssk_pkg::hcnt_t'(lssk_pkg::HASH_STEPS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - lssk_pkg::hcnt_t'(1);
			if (cnt_q == lssk_pkg::hcnt_t'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Magnitude shifter and partial remainder.
	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= mag_abs;
			rem_q <= '0;
		end else if (busy_q) begin
			mag_q <= mag_q << lssk_pkg::HASH_BITS;
			rem_q <= rem_next;
		end
	end

endmodule

// File: design/lssk_datapath.sv
// Datapath: prefix sum, probe pointers, table memory, best length and result register.
module lssk_datapath (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic signed [63:0]        cfg_wr_data,
	input  logic signed [31:0]        element_value,
	input  logic                      last_element,
	input  lssk_pkg::cmd_t            cmd,
	output lssk_pkg::status_t         st,
	output logic [15:0]               longest_length,
	output logic                      final_result,
	output logic                      capacity_overflow
);

	// Run state.
	lssk_pkg::key_t   target_q;
	lssk_pkg::key_t   sum_q;
	lssk_pkg::pos_t   pos_q;
	lssk_pkg::pos_t   best_q;
	logic             ovf_q;
	lssk_pkg::epoch_t epoch_q;
	lssk_pkg::idx_t   clr_q;

	// Per-item working registers.
	logic             last_q;
	logic             limit_q;
	lssk_pkg::key_t   key_q;
	lssk_pkg::idx_t   idx_q;
	lssk_pkg::idx_t   cnt_q;

	// Result register.
	lssk_pkg::pos_t   len_out_q;
	logic             final_out_q;
	logic             ovf_out_q;

	lssk_pkg::key_t   elem_ext;
	lssk_pkg::idx_t   idx_next;
	lssk_pkg::idx_t   hash_slot;
	logic             hash_done;
	lssk_pkg::entry_t rd_entry;
	lssk_pkg::entry_t wr_entry;
	lssk_pkg::idx_t   waddr;
	lssk_pkg::idx_t   raddr;
	logic             we;
	lssk_pkg::pos_t   run_len;

	assign elem_ext = {{(lssk_pkg::KEY_W - lssk_pkg::ELEM_W){element_value[lssk_pkg::ELEM_W-1]}},
		element_value};
	assign idx_next = (idx_q == lssk_pkg::idx_t'(lssk_pkg::TABLE_DEPTH - 1)) ?
		'0 : idx_q + lssk_pkg::idx_t'(1);
	assign run_len  = pos_q - rd_entry.pos;

	// Home slot of the current key.
	lssk_hash u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.hash_start),
		.key    (key_q),
		.done   (hash_done),
		.slot   (hash_slot)
	);

	// Table memory ports: clearing pass writes epoch zero, inserts write the current sum.
	always_comb begin
		we             = cmd.insert | cmd.clr_write;
		waddr          = cmd.clr_write ? clr_q : idx_q;
		wr_entry.epoch = cmd.clr_write ? '0 : epoch_q;
		wr_entry.sum   = sum_q;
		wr_entry.pos   = pos_q;
		raddr          = cmd.probe_first ? hash_slot : idx_next;
	end

	lssk_ram #(
		.WIDTH ($bits(lssk_pkg::entry_t)),
		.DEPTH (lssk_pkg::TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wr_entry),
		.raddr (raddr),
		.rdata (rd_entry)
	);

	// Status back to the controller.
	always_comb begin
		st.limit_hit   = (pos_q >= lssk_pkg::ITEM_LIMIT);
		st.hash_done   = hash_done;
		st.entry_valid = (rd_entry.epoch == epoch_q);
		st.key_match   = (rd_entry.sum == key_q);
		st.probe_last  = (cnt_q == lssk_pkg::idx_t'(lssk_pkg::TABLE_DEPTH - 1));
		st.last_item   = last_q;
		st.clr_last    = (clr_q == lssk_pkg::idx_t'(lssk_pkg::TABLE_DEPTH - 1));
		st.epoch_wrap  = (epoch_q == lssk_pkg::EPOCH_LAST);
	end

	// Target register, written through the configuration port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
		end else if (cfg_wr_en) begin
			target_q <= cfg_wr_data;
		end
	end

	// Run state: sum, position, best length, overflow flag, epoch.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			pos_q   <= '0;
			best_q  <= '0;
			ovf_q   <= 1'b0;
			epoch_q <= lssk_pkg::EPOCH_FIRST;
		end else begin
			if (cmd.load_item) begin
				if (st.limit_hit) begin
					ovf_q <= 1'b1;
				end else begin
					sum_q <= sum_q + elem_ext;
				end
			end
			if (cmd.load_key && !cmd.phase_b && (sum_q == target_q)) begin
				best_q <= pos_q + lssk_pkg::pos_t'(1);
			end
			if (cmd.hit_update && (rd_entry.pos < pos_q) && (run_len > best_q)) begin
				best_q <= run_len;
			end
			if (cmd.set_ovf) begin
				ovf_q <= 1'b1;
			end
			if (cmd.finish) begin
				if (last_q) begin
					sum_q   <= '0;
					pos_q   <= '0;
					best_q  <= '0;
					ovf_q   <= 1'b0;
					epoch_q <= st.epoch_wrap ? lssk_pkg::EPOCH_FIRST :
						epoch_q + lssk_pkg::epoch_t'(1);
				end else if (!limit_q) begin
					pos_q <= pos_q + lssk_pkg::pos_t'(1);
				end
			end
		end
	end

	// Clearing pass address.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_write) begin
			clr_q <= st.clr_last ? '0 : clr_q + lssk_pkg::idx_t'(1);
		end
	end

	// Item flags, probe key, probe slot and probe count.
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			last_q  <= last_element;
			limit_q <= st.limit_hit;
		end
		if (cmd.load_key) begin
			key_q <= cmd.phase_b ? sum_q : sum_q - target_q;
		end
		if (cmd.probe_first) begin
			idx_q <= hash_slot;
			cnt_q <= '0;
		end else if (cmd.probe_next) begin
			idx_q <= idx_next;
			cnt_q <= cnt_q + lssk_pkg::idx_t'(1);
		end
	end

	// Result register, loaded when the item finishes.
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			len_out_q   <= best_q;
			final_out_q <= last_q;
			ovf_out_q   <= ovf_q;
		end
	end

	assign longest_length    = len_out_q;
	assign final_result      = final_out_q;
	assign capacity_overflow = ovf_out_q;

endmodule

// File: design/lssk_ctrl.sv
// Controller: sequences accept, key setup, hashing, probing, insert, result and clearing.
module lssk_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  lssk_pkg::status_t   st,
	output lssk_pkg::cmd_t      cmd
);

	lssk_pkg::state_t state_q;
	lssk_pkg::state_t state_d;
	logic             phase_q;
	logic             phase_d;
	logic             out_valid_q;
	logic             hit;

	assign hit = st.entry_valid && st.key_match;

	// State, probe phase and result-valid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lssk_pkg::S_CLEAR;
			phase_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			phase_q     <= phase_d;
			out_valid_q <= cmd.finish | (out_valid_q & ~out_ready);
		end
	end

	// Next state and commands.
	always_comb begin
		state_d     = state_q;
		phase_d     = phase_q;
		cmd         = '0;
		cmd.phase_b = phase_q;
		in_ready    = 1'b0;
		case (state_q)
			lssk_pkg::S_CLEAR: begin
				cmd.clr_write = 1'b1;
				if (st.clr_last) begin
					state_d = lssk_pkg::S_IDLE;
				end
			end
			lssk_pkg::S_IDLE: begin
				in_ready = 1'b1;
				phase_d  = 1'b0;
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_d = st.limit_hit ? lssk_pkg::S_RESULT : lssk_pkg::S_KEY;
				end
			end
			lssk_pkg::S_KEY: begin
				cmd.load_key = 1'b1;
				state_d      = lssk_pkg::S_HSTART;
			end
			lssk_pkg::S_HSTART: begin
				cmd.hash_start = 1'b1;
				state_d        = lssk_pkg::S_HWAIT;
			end
			lssk_pkg::S_HWAIT: begin
				if (st.hash_done) begin
					cmd.probe_first = 1'b1;
					state_d         = lssk_pkg::S_CHECK;
				end
			end
			lssk_pkg::S_CHECK: begin
				if (!phase_q) begin
					// Lookup of sum minus target: stop on a hit, an empty slot or a full sweep.
					if (hit || !st.entry_valid || st.probe_last) begin
						cmd.hit_update = hit;
						phase_d        = 1'b1;
						state_d        = lssk_pkg::S_KEY;
					end else begin
						cmd.probe_next = 1'b1;
					end
				end else begin
					// Find or insert the current sum; a full sweep with no free slot sets the overflow flag.
					if (hit) begin
						state_d = lssk_pkg::S_RESULT;
					end else if (!st.entry_valid) begin
						cmd.insert = 1'b1;
						state_d    = lssk_pkg::S_RESULT;
					end else if (st.probe_last) begin
						cmd.set_ovf = 1'b1;
						state_d     = lssk_pkg::S_RESULT;
					end else begin
						cmd.probe_next = 1'b1;
					end
				end
			end
			lssk_pkg::S_RESULT: begin
				if (!out_valid_q || out_ready) begin
					cmd.finish = 1'b1;
					state_d = (st.last_item && st.epoch_wrap) ?
						lssk_pkg::S_CLEAR : lssk_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = lssk_pkg::S_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

// File: design/longest_subarray_sum_k.sv
// Longest subarray with sum equal to target_sum: one signed element in, one length out.
// Each accepted element updates a 64-bit prefix sum, looks up (sum - target_sum) and then
// looks up or inserts the sum in a linear-probing table of TABLE_DEPTH entries kept in a
// single RAM with one write and one registered read port; one result is returned per element,
// and the one for an element marked last carries final_result and ends the array. For each
// of the two lookups the controller sets up the key, starts the home-slot reduction, waits
// for it and probes the table, at least one slot and more on collisions. The reduction takes
// the low key bits when TABLE_DEPTH is a power of two, otherwise it folds 4 key bits per
// cycle. An element arriving after the item limit is reached skips both lookups and goes
// straight to its result. While a result waits on out_ready the next element is
// still accepted and processed. Entries are tagged with an 8-bit array epoch, so ending an
// array needs no table sweep, except that after reset and after every 255th array the block
// runs a clearing pass over all TABLE_DEPTH entries (1024 by default) during which in_ready is
// low; configuration writes are taken at any time the block is idle.
module longest_subarray_sum_k (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic signed [63:0] cfg_wr_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] element_value,
	input  logic               last_element,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [15:0]        longest_length,
	output logic               final_result,
	output logic               capacity_overflow
);

	lssk_pkg::cmd_t    cmd;
	lssk_pkg::status_t st;

	// Sequencer.
	lssk_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.st        (st),
		.cmd       (cmd)
	);

	// Arithmetic, table and result register.
	lssk_datapath u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_wr_en         (cfg_wr_en),
		.cfg_wr_data       (cfg_wr_data),
		.element_value     (element_value),
		.last_element      (last_element),
		.cmd               (cmd),
		.st                (st),
		.longest_length    (longest_length),
		.final_result      (final_result),
		.capacity_overflow (capacity_overflow)
	);

endmodule

// File: design/lssk_checker.sv
// Port-level checker for the longest subarray sum block, bound to the top level.
module lssk_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [15:0]        longest_length,
	input logic               final_result,
	input logic               capacity_overflow
);

	logic        in_xfer;
	logic        out_xfer;
	logic [2:0]  pend_q;
	logic        in_run_q;
	logic        ovf_seen_q;
	logic [15:0] prev_len_q;

	assign in_xfer  = in_valid && in_ready;
	assign out_xfer = out_valid && out_ready;

	// Track items in flight and what earlier results of the same array showed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q     <= '0;
			in_run_q   <= 1'b0;
			ovf_seen_q <= 1'b0;
			prev_len_q <= '0;
		end else begin
			pend_q <= pend_q + {2'b00, in_xfer} - {2'b00, out_xfer};
			if (out_xfer) begin
				in_run_q   <= !final_result;
				ovf_seen_q <= !final_result && capacity_overflow;
				prev_len_q <= longest_length;
			end
		end
	end

	// A stalled result holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(longest_length) &&
			$stable(final_result) && $stable(capacity_overflow))
		else $error("result changed while stalled");

	// A result is never shown without an accepted element behind it.
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pend_q != 3'd0))
		else $error("result without an accepted element");

	// At most one element in work plus one result waiting.
	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 3'd2)
		else $error("too many elements in flight");

	// The best length never shrinks within one array.
	a_len_monotone: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer && in_run_q |-> longest_length >= prev_len_q)
		else $error("longest length decreased within an array");

	// The overflow flag stays set until the array ends.
	a_ovf_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer && ovf_seen_q |-> capacity_overflow)
		else $error("overflow flag dropped within an array");

endmodule

bind longest_subarray_sum_k lssk_checker u_lssk_checker (.*);
